// ----- hw/rtl/lge_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life generation engine
// Opcode codes, register indexes, life rule counts and the population counter
// helper.
// ----------------------------------------------------------------------------
package lge_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } lge_op_e;

  // Configuration register indexes (decoded from the word address)
  localparam logic REG_IDX_COLS = 1'b0;
  localparam logic REG_IDX_ROWS = 1'b1;

  localparam logic [6:0] COLS_RESET = 7'd50;
  localparam logic [5:0] ROWS_RESET = 6'd20;

  // Wide enough for any grid dimension up to 256
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned MIN_DIM = 2;

  // Life rule: neighbor counts
  localparam int unsigned NBR_W       = 4;
  localparam int unsigned BIRTH_COUNT = 3;
  localparam int unsigned KEEP_COUNT  = 2;

  // Population counter: cells counted per cycle
  localparam int unsigned POP_CHUNK = 8;
  localparam int unsigned POPC_W    = 4;
  localparam logic [11:0] POP_SAT   = 12'd4095;

  function automatic logic [POPC_W-1:0] popcount_chunk(input logic [POP_CHUNK-1:0] v);
    logic [POPC_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < POP_CHUNK; i++) begin
      sum = sum + POPC_W'(v[i]);
    end
    return sum;
  endfunction

endpackage

// ----- hw/rtl/lge_row_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_row_calc: next generation of one grid row
// One lane per column counts the eight neighbors from the rows above, at and
// below, and applies the B3/S23 rule. Lanes past the columns in use end dead.
// ----------------------------------------------------------------------------
module lge_row_calc
  import lge_pkg::*;
#(
  parameter int unsigned COLS = 64
) (
  input  logic [COLS-1:0] row_above_i,
  input  logic [COLS-1:0] row_mid_i,
  input  logic [COLS-1:0] row_below_i,
  input  logic [COLS-1:0] col_mask_i,
  output logic [COLS-1:0] row_next_o
);

  // Pad one dead cell on each side: cell c sits at bit c+1
  logic [COLS+1:0] above_p;
  logic [COLS+1:0] mid_p;
  logic [COLS+1:0] below_p;
  logic [NBR_W-1:0] nbr [COLS];

  assign above_p = {1'b0, row_above_i, 1'b0};
  assign mid_p   = {1'b0, row_mid_i, 1'b0};
  assign below_p = {1'b0, row_below_i, 1'b0};

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      nbr[c] = NBR_W'(above_p[c]) + NBR_W'(above_p[c+1]) + NBR_W'(above_p[c+2])
             + NBR_W'(mid_p[c])                           + NBR_W'(mid_p[c+2])
             + NBR_W'(below_p[c]) + NBR_W'(below_p[c+1]) + NBR_W'(below_p[c+2]);
      row_next_o[c] = col_mask_i[c]
                    & ((nbr[c] == NBR_W'(BIRTH_COUNT))
                     | (mid_p[c+1] & (nbr[c] == NBR_W'(KEEP_COUNT))));
    end
  end

endmodule

// ----- hw/rtl/life_generation_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_engine_unit: Game of Life engine, rule B3/S23
// Bounded, non-wrapping grid of one-bit cells with cell write, cell read,
// grid clear and one-generation advance.
// ----------------------------------------------------------------------------
// The grid lives in one synchronous memory, one word per row (MAX_COLS cells
// per word), with two banks: the current generation and the spare one that an
// advance fills. Items are taken one at a time. A cell write or read does a row
// read, then modifies and writes back or answers; a clear, and a cell access
// outside the grid in use, skips the memory. An advance reads the first row,
// then for each row in use does one memory read for the row below, forms and
// writes the new row, and the population counter then adds 8 cells per cycle.
// A flip-flop valid bit per row marks rows of the current bank that hold data;
// a clear only drops these bits, so reset and clear need no pass over the
// memory. A finished result sits in the output register and the block accepts
// the next item while it waits there.
// ----------------------------------------------------------------------------
module life_generation_engine_unit
  import lge_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  cell_column_i,
  input  logic [4:0]  cell_row_i,
  input  logic        cell_value_i,

  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  done_kind_o,
  output logic        read_value_o,
  output logic [11:0] population_o,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ROW_SLOTS = 2 ** ROW_W;
  localparam int unsigned ADDR_W    = ROW_W + 1;
  localparam int unsigned MEM_DEPTH = 2 * ROW_SLOTS;
  localparam int unsigned POP_STEPS = (MAX_COLS + POP_CHUNK - 1) / POP_CHUNK;
  localparam int unsigned POP_SR_W  = POP_STEPS * POP_CHUNK;
  localparam int unsigned STEP_W    = (POP_STEPS > 1) ? $clog2(POP_STEPS) : 1;
  localparam int unsigned ACC_W     = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int unsigned SAT_CMP_W = (ACC_W > 12) ? ACC_W : 12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHORT,      // clear, or cell access outside the grid in use
    S_CELL_RD,
    S_CELL_DONE,
    S_ADV_FIRST,
    S_ADV_FILL,
    S_ADV_FETCH,
    S_ADV_CALC,
    S_ADV_COUNT,
    S_ADV_DONE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] grid_columns_q;
  logic [5:0] grid_rows_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= COLS_RESET;
      grid_rows_q    <= ROWS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_IDX_COLS) begin
        grid_columns_q <= pwdata[6:0];
      end else begin
        grid_rows_q <= pwdata[5:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IDX_ROWS) ? {26'd0, grid_rows_q} : {25'd0, grid_columns_q};

  // Clamp the sizes into 2..MAX
  logic [DIM_W-1:0] cols_raw;
  logic [DIM_W-1:0] rows_raw;
  logic [DIM_W-1:0] used_cols;
  logic [DIM_W-1:0] used_rows;
  logic [MAX_COLS-1:0] col_mask;

  assign cols_raw = DIM_W'(grid_columns_q);
  assign rows_raw = DIM_W'(grid_rows_q);

  always_comb begin
    if (cols_raw < DIM_W'(MIN_DIM)) begin
      used_cols = DIM_W'(MIN_DIM);
    end else if (cols_raw > DIM_W'(MAX_COLS)) begin
      used_cols = DIM_W'(MAX_COLS);
    end else begin
      used_cols = cols_raw;
    end
    if (rows_raw < DIM_W'(MIN_DIM)) begin
      used_rows = DIM_W'(MIN_DIM);
    end else if (rows_raw > DIM_W'(MAX_ROWS)) begin
      used_rows = DIM_W'(MAX_ROWS);
    end else begin
      used_rows = rows_raw;
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = DIM_W'(c) < used_cols;
    end
  end

  // --------------------------------------------------------------------------
  // Grid memory: address {bank, row}, one row per word, registered read
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] grid_mem [MEM_DEPTH];
  logic                mem_re;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [MAX_COLS-1:0] mem_rdata_q;
  logic                rd_valid_q;
  logic [ROW_SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= grid_mem[mem_raddr];
      rd_valid_q  <= valid_q[mem_raddr[ROW_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Control and datapath
  // --------------------------------------------------------------------------
  state_e              state_q;
  lge_op_e             op_q;
  logic [5:0]          col_q;
  logic [4:0]          row_q;
  logic                val_q;
  logic                inside_q;
  logic                bank_q;
  logic [ROW_W-1:0]    row_cnt_q;
  logic [STEP_W-1:0]   step_q;
  logic [MAX_COLS-1:0] prev_q;
  logic [MAX_COLS-1:0] cur_q;
  logic [POP_SR_W-1:0] pop_sr_q;
  logic [ACC_W-1:0]    pop_acc_q;

  logic                out_valid_q;
  logic [1:0]          done_kind_q;
  logic                read_value_q;
  logic [11:0]         population_q;

  logic                in_accept;
  logic                out_free;
  logic                res_load;
  logic                inside_in;
  logic [COL_W-1:0]    col_idx;
  logic [ROW_W-1:0]    row_idx;
  logic                has_below;
  logic [MAX_COLS-1:0] rdata_eff;
  logic [MAX_COLS-1:0] rdata_adv;
  logic [MAX_COLS-1:0] below_row;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] cell_wdata;
  logic [11:0]         pop_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  // The output register can take a result this cycle
  assign out_free   = ~out_valid_q | ~out_stall_i;
  // A new result enters the output register this cycle
  assign res_load   = out_free && (state_q inside {S_SHORT, S_CELL_DONE, S_ADV_DONE});

  assign inside_in = (DIM_W'(cell_column_i) < used_cols) && (DIM_W'(cell_row_i) < used_rows);
  assign col_idx   = COL_W'(col_q);
  assign row_idx   = ROW_W'(row_q);
  assign has_below = (DIM_W'(row_cnt_q) + DIM_W'(1)) < used_rows;

  // A row never written since the last clear or advance reads as all dead
  assign rdata_eff = rd_valid_q ? mem_rdata_q : '0;
  // Cells kept past the columns in use are not seen by an advance
  assign rdata_adv = rdata_eff & col_mask;
  assign below_row = has_below ? rdata_adv : '0;

  always_comb begin
    cell_wdata          = rdata_eff;
    cell_wdata[col_idx] = val_q;
  end

  assign pop_sat = (SAT_CMP_W'(pop_acc_q) > SAT_CMP_W'(POP_SAT)) ? POP_SAT : 12'(pop_acc_q);

  lge_row_calc #(
    .COLS (MAX_COLS)
  ) u_row_calc (
    .row_above_i (prev_q),
    .row_mid_i   (cur_q),
    .row_below_i (below_row),
    .col_mask_i  (col_mask),
    .row_next_o  (next_row)
  );

  // Memory port steering. Reads hit the current bank, advance writes hit the
  // spare bank, and a cell write lands before the next item is taken, so no
  // access overlaps another on the same word.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {bank_q, row_idx};
    mem_we    = 1'b0;
    mem_waddr = {bank_q, row_idx};
    mem_wdata = cell_wdata;
    case (state_q)
      S_CELL_RD: begin
        mem_re = 1'b1;
      end
      S_CELL_DONE: begin
        mem_we = out_free && (op_q == OP_WRITE);
      end
      S_ADV_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = {bank_q, ROW_W'(0)};
      end
      S_ADV_FETCH: begin
        mem_re    = has_below;
        mem_raddr = {bank_q, row_cnt_q + ROW_W'(1)};
      end
      S_ADV_CALC: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_q, row_cnt_q};
        mem_wdata = next_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_WRITE;
      col_q        <= '0;
      row_q        <= '0;
      val_q        <= 1'b0;
      inside_q     <= 1'b0;
      bank_q       <= 1'b0;
      valid_q      <= '0;
      row_cnt_q    <= '0;
      step_q       <= '0;
      prev_q       <= '0;
      cur_q        <= '0;
      pop_sr_q     <= '0;
      pop_acc_q    <= '0;
      out_valid_q  <= 1'b0;
      done_kind_q  <= '0;
      read_value_q <= 1'b0;
      population_q <= '0;
    end else begin
      // Drop the result once the sink takes it, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !res_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q     <= lge_op_e'(opcode_i);
            col_q    <= cell_column_i;
            row_q    <= cell_row_i;
            val_q    <= cell_value_i;
            inside_q <= inside_in;
            case (lge_op_e'(opcode_i))
              OP_WRITE, OP_READ: begin
                state_q <= inside_in ? S_CELL_RD : S_SHORT;
              end
              OP_ADVANCE: begin
                state_q <= S_ADV_FIRST;
              end
              default: begin
                state_q <= S_SHORT;
              end
            endcase
          end
        end

        S_SHORT: begin
          if (out_free) begin
            if (op_q == OP_CLEAR) begin
              valid_q <= '0;
            end
            out_valid_q  <= 1'b1;
            done_kind_q  <= op_q;
            read_value_q <= 1'b0;
            population_q <= '0;
            state_q      <= S_IDLE;
          end
        end

        S_CELL_RD: begin
          state_q <= S_CELL_DONE;
        end

        // Hold the read row until the result can leave, then write back
        S_CELL_DONE: begin
          if (out_free) begin
            if (op_q == OP_WRITE) begin
              valid_q[row_idx] <= 1'b1;
            end
            out_valid_q  <= 1'b1;
            done_kind_q  <= op_q;
            read_value_q <= (op_q == OP_READ) && inside_q && rdata_eff[col_idx];
            population_q <= '0;
            state_q      <= S_IDLE;
          end
        end

        S_ADV_FIRST: begin
          state_q <= S_ADV_FILL;
        end

        // Prime the window: no row above the first one
        S_ADV_FILL: begin
          prev_q    <= '0;
          cur_q     <= rdata_adv;
          row_cnt_q <= '0;
          pop_acc_q <= '0;
          state_q   <= S_ADV_FETCH;
        end

        S_ADV_FETCH: begin
          state_q <= S_ADV_CALC;
        end

        // New row goes to the spare bank; slide the window down one row
        S_ADV_CALC: begin
          pop_sr_q <= POP_SR_W'(next_row);
          prev_q   <= cur_q;
          cur_q    <= below_row;
          step_q   <= '0;
          state_q  <= S_ADV_COUNT;
        end

        S_ADV_COUNT: begin
          pop_acc_q <= pop_acc_q + ACC_W'(popcount_chunk(pop_sr_q[POP_CHUNK-1:0]));
          pop_sr_q  <= pop_sr_q >> POP_CHUNK;
          step_q    <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(POP_STEPS - 1)) begin
            if (has_below) begin
              row_cnt_q <= row_cnt_q + ROW_W'(1);
              state_q   <= S_ADV_FETCH;
            end else begin
              state_q <= S_ADV_DONE;
            end
          end
        end

        // Swap banks; rows past those in use were not written and read dead
        S_ADV_DONE: begin
          if (out_free) begin
            bank_q <= ~bank_q;
            for (int i = 0; i < ROW_SLOTS; i++) begin
              valid_q[i] <= DIM_W'(i) < used_rows;
            end
            out_valid_q  <= 1'b1;
            done_kind_q  <= OP_ADVANCE;
            read_value_q <= 1'b0;
            population_q <= pop_sat;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign done_kind_o  = done_kind_q;
  assign read_value_o = read_value_q;
  assign population_o = population_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_adv_writes_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADV_CALC) |-> (mem_we && (mem_waddr[ROW_W] == ~bank_q)))
    else $error("advance wrote into the current bank");

  a_bank_swaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADV_DONE && out_free) |=> (bank_q != $past(bank_q)))
    else $error("bank did not swap at the end of an advance");

  a_clear_drops_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHORT && op_q == OP_CLEAR && out_free) |=> (valid_q == '0))
    else $error("clear left rows marked valid");

  a_pop_only_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (done_kind_o != OP_ADVANCE)) |-> (population_o == '0))
    else $error("population reported on a non-advance result");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADV_COUNT) |-> (step_q <= STEP_W'(POP_STEPS - 1)))
    else $error("population step counter ran past the row");

endmodule
